/* sv/lzd_pkg.sv */
// Package for the LZSS decoder: shared types, codes and default sizes.
// No dependencies; the sequencer, the result stage, the top level and the testbench import it.
`default_nettype none

package lzd_pkg;

   localparam int OFFSET_BITS_DEF = 11;
   localparam int LENGTH_BITS_DEF = 4;
   localparam int BYTE_BITS       = 8;
   localparam int SIZE_BITS       = 31;
   localparam logic [7:0] SPACE_CHAR = 8'h20;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_OVF   = 2'd1,
      STAT_SHORT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_LIT,
      PH_PAIR
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BIT,
      S_PUT,
      S_READ,
      S_COPY,
      S_FIN,
      S_LAST
   } state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       has;
      logic       done;
      status_type status;
   } result_type;

   typedef struct packed {
      logic       push;
      logic       flush;
      result_type res;
   } out_ctl_type;

endpackage

`default_nettype wire

/* sv/lzss_decoder_top.sv */
`default_nettype none
// LZSS stream decoder top level (offset and length widths set by parameters).
// Instantiates lzd_core, lzd_hist and lzd_out; depends on lzd_pkg.
//
//   channel | direction | ports                                   | carries
//   req     | in        | req_valid/req_ready, compressed_byte,   | one stream byte
//           |           | stream_start, stream_end                |
//   rsp     | out       | rsp_valid/rsp_ready, data_byte,         | one decoded byte
//           |           | has_byte, run_last, stream_done, status | or a status item
//   csr     | in        | csr_valid/csr_ready, expected_size      | declared length
//
// Sequence: a request is accepted, then its eight stream bits are taken in turn; a literal
// is emitted in its own step, each copied byte takes a history RAM read, then an emit
// and write back, and the closing states S_FIN and S_LAST end the request; a full pair
// token copies 17 bytes. The copy loop through the registered RAM read port sets the pace.
// Reset: the history window gets no clearing pass; a fill count tracks the entries
// written in this stream, and any other entry reads as its start value.
// Stalls: with rsp_ready low the sequencer waits once both the staging slot and
// the output register are full; req_ready is high only between requests.

module lzss_decoder_top #(
   parameter int OFFSET_BITS = lzd_pkg::OFFSET_BITS_DEF,
   parameter int LENGTH_BITS = lzd_pkg::LENGTH_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [7:0]                    req_compressed_byte,
   input  wire logic                          req_stream_start,
   input  wire logic                          req_stream_end,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [7:0]                    rsp_data_byte,
   output      logic                          rsp_has_byte,
   output      logic                          rsp_run_last,
   output      logic                          rsp_stream_done,
   output      logic [1:0]                    rsp_status,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [lzd_pkg::SIZE_BITS-1:0] csr_expected_size
);
   import lzd_pkg::*;

   // History RAM port signals between the sequencer and the window memory.
   logic                   mem_wr_en;
   logic [OFFSET_BITS-1:0] mem_wr_addr;
   logic [7:0]             mem_wr_data;
   logic                   mem_rd_en;
   logic [OFFSET_BITS-1:0] mem_rd_addr;
   logic [7:0]             mem_rd_data;

   // Result hand-off: the sequencer pushes results and flushes the last one of
   // each request, so that run_last can be set once no further result follows.
   out_ctl_type out_ctl;
   logic        out_ready;

   lzd_core #(
      .OFFSET_BITS(OFFSET_BITS),
      .LENGTH_BITS(LENGTH_BITS)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_compressed_byte(req_compressed_byte),
      .req_stream_start   (req_stream_start),
      .req_stream_end     (req_stream_end),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_expected_size  (csr_expected_size),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_data        (mem_wr_data),
      .mem_rd_en          (mem_rd_en),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_data        (mem_rd_data),
      .out_ctl            (out_ctl),
      .out_ready          (out_ready)
   );

   lzd_hist #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_hist (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   lzd_out u_out (
      .clock          (clock),
      .reset          (reset),
      .ctl            (out_ctl),
      .ready          (out_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_done(rsp_stream_done),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

/* sv/lzd_hist.sv */
// History window RAM of the LZSS decoder: one write and one registered read port.
// Depends on nothing but its parameter.
`default_nettype none

module lzd_hist #(
   parameter int OFFSET_BITS = 11
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [OFFSET_BITS-1:0] wr_addr,
   input  wire logic [7:0]             wr_data,
   input  wire logic                   rd_en,
   input  wire logic [OFFSET_BITS-1:0] rd_addr,
   output      logic [7:0]             rd_data
);

   logic [7:0] mem [2**OFFSET_BITS];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/lzd_out.sv */
// Result stage of the LZSS decoder: one staging slot plus the output register.
// The staging slot lets the last result of a request be marked once it is known.
// Depends on lzd_pkg.
`default_nettype none

module lzd_out (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lzd_pkg::out_ctl_type ctl,
   output      logic                 ready,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [7:0]           rsp_data_byte,
   output      logic                 rsp_has_byte,
   output      logic                 rsp_run_last,
   output      logic                 rsp_stream_done,
   output      logic [1:0]           rsp_status
);
   import lzd_pkg::*;

   logic       pend_v_ff, pend_v_in;
   result_type pend_ff, pend_in;
   logic       out_v_ff, out_v_in;
   result_type out_ff, out_in;
   logic       last_ff, last_in;
   logic       out_free;

   assign out_free = !out_v_ff || rsp_ready;
   assign ready    = !pend_v_ff || out_free;

   always_comb begin
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      out_v_in  = out_v_ff && !rsp_ready;
      out_in    = out_ff;
      last_in   = last_ff;
      if (ready && (ctl.push || ctl.flush)) begin
         if (pend_v_ff) begin
            out_in   = pend_ff;
            out_v_in = 1'b1;
            last_in  = ctl.flush;
         end
         if (ctl.push) begin
            pend_in   = ctl.res;
            pend_v_in = 1'b1;
         end else begin
            pend_v_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_data_byte   = out_ff.data;
   assign rsp_has_byte    = out_ff.has;
   assign rsp_run_last    = last_ff;
   assign rsp_stream_done = out_ff.done;
   assign rsp_status      = out_ff.status;

endmodule

`default_nettype wire

/* sv/lzd_core.sv */
// Bit sequencer of the LZSS decoder: token parsing, copy loop, counters and status.
// Drives the history RAM and the result stage. Depends on lzd_pkg.
`default_nettype none

module lzd_core #(
   parameter int OFFSET_BITS = lzd_pkg::OFFSET_BITS_DEF,
   parameter int LENGTH_BITS = lzd_pkg::LENGTH_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [7:0]                   req_compressed_byte,
   input  wire logic                         req_stream_start,
   input  wire logic                         req_stream_end,
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire logic [lzd_pkg::SIZE_BITS-1:0] csr_expected_size,
   output      logic                         mem_wr_en,
   output      logic [OFFSET_BITS-1:0]       mem_wr_addr,
   output      logic [7:0]                   mem_wr_data,
   output      logic                         mem_rd_en,
   output      logic [OFFSET_BITS-1:0]       mem_rd_addr,
   input  wire logic [7:0]                   mem_rd_data,
   output      lzd_pkg::out_ctl_type         out_ctl,
   input  wire logic                         out_ready
);
   import lzd_pkg::*;

   localparam int TOK_BITS = OFFSET_BITS + LENGTH_BITS;
   localparam int NEED_W   = $clog2(TOK_BITS + 1);
   localparam int WIN_SIZE = 2**OFFSET_BITS;
   localparam logic [OFFSET_BITS-1:0] FILL_POS =
      OFFSET_BITS'(WIN_SIZE - (2**LENGTH_BITS) - 1);
   localparam logic [OFFSET_BITS:0] FILL_FULL = (OFFSET_BITS+1)'(WIN_SIZE);

   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   end_ff, end_in;
   logic [3:0]             bits_left_ff, bits_left_in;
   logic [TOK_BITS-1:0]    tok_ff, tok_in;
   logic [NEED_W-1:0]      need_ff, need_in;
   logic [OFFSET_BITS-1:0] wpos_ff, wpos_in;
   logic [OFFSET_BITS:0]   fill_ff, fill_in;
   logic [SIZE_BITS-1:0]   written_ff, written_in;
   logic                   err_ff, err_in;
   logic [SIZE_BITS-1:0]   exp_ff, exp_in;
   logic [OFFSET_BITS-1:0] src_ff, src_in;
   logic [LENGTH_BITS:0]   left_ff, left_in;
   logic                   hit_ff, hit_in;
   logic [7:0]             dflt_ff, dflt_in;

   logic                   do_put;
   logic [7:0]             put_data;
   logic                   ovf;
   logic                   bit_now;
   logic [TOK_BITS-1:0]    tok_next;
   logic [OFFSET_BITS-1:0] rel;
   state_type              after_tok;

   assign ovf       = written_ff >= exp_ff;
   assign bit_now   = byte_ff[7];
   assign tok_next  = {tok_ff[TOK_BITS-2:0], bit_now};
   assign rel       = src_ff - FILL_POS;
   assign after_tok = (bits_left_ff == 4'd0) ? S_FIN : S_BIT;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      byte_in      = byte_ff;
      end_in       = end_ff;
      bits_left_in = bits_left_ff;
      tok_in       = tok_ff;
      need_in      = need_ff;
      wpos_in      = wpos_ff;
      fill_in      = fill_ff;
      written_in   = written_ff;
      err_in       = err_ff;
      exp_in       = exp_ff;
      src_in       = src_ff;
      left_in      = left_ff;
      hit_in       = hit_ff;
      dflt_in      = dflt_ff;
      req_ready    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wpos_ff;
      mem_wr_data  = 8'd0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = src_ff;
      out_ctl      = '0;
      do_put       = 1'b0;
      put_data     = 8'd0;

      if (csr_valid) begin
         exp_in = csr_expected_size;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               byte_in      = req_compressed_byte;
               end_in       = req_stream_end;
               bits_left_in = 4'(BYTE_BITS);
               if (req_stream_start) begin
                  wpos_in    = FILL_POS;
                  fill_in    = '0;
                  tok_in     = '0;
                  need_in    = NEED_W'(1);
                  phase_in   = PH_FLAG;
                  written_in = '0;
                  err_in     = 1'b0;
               end
               state_in = S_BIT;
            end
         end
         S_BIT: begin
            if (err_ff) begin
               state_in = S_FIN;
            end else begin
               byte_in      = {byte_ff[6:0], 1'b0};
               bits_left_in = bits_left_ff - 4'd1;
               state_in     = (bits_left_ff == 4'd1) ? S_FIN : S_BIT;
               if (phase_ff == PH_FLAG) begin
                  tok_in = '0;
                  if (bit_now) begin
                     phase_in = PH_LIT;
                     need_in  = NEED_W'(BYTE_BITS);
                  end else begin
                     phase_in = PH_PAIR;
                     need_in  = NEED_W'(TOK_BITS);
                  end
               end else begin
                  tok_in  = tok_next;
                  need_in = need_ff - NEED_W'(1);
                  if (need_ff == NEED_W'(1)) begin
                     // Token complete: emit a literal or start the copy.
                     phase_in = PH_FLAG;
                     need_in  = NEED_W'(1);
                     if (phase_ff == PH_LIT) begin
                        state_in = S_PUT;
                     end else begin
                        src_in   = tok_next[TOK_BITS-1:LENGTH_BITS];
                        left_in  = {1'b0, tok_next[LENGTH_BITS-1:0]} + (LENGTH_BITS+1)'(2);
                        state_in = S_READ;
                     end
                  end
               end
            end
         end
         S_PUT: begin
            do_put   = 1'b1;
            put_data = tok_ff[7:0];
            if (out_ready) begin
               state_in = ovf ? S_FIN : after_tok;
            end
         end
         S_READ: begin
            mem_rd_en = 1'b1;
            hit_in    = {1'b0, rel} < fill_ff;
            dflt_in   = (src_ff < FILL_POS) ? SPACE_CHAR : 8'd0;
            state_in  = S_COPY;
         end
         S_COPY: begin
            do_put   = 1'b1;
            put_data = hit_ff ? mem_rd_data : dflt_ff;
            if (out_ready) begin
               if (ovf || left_ff == (LENGTH_BITS+1)'(1)) begin
                  state_in = ovf ? S_FIN : after_tok;
               end else begin
                  left_in  = left_ff - (LENGTH_BITS+1)'(1);
                  src_in   = src_ff + OFFSET_BITS'(1);
                  state_in = S_READ;
               end
            end
         end
         S_FIN: begin
            if (!end_ff) begin
               state_in = S_LAST;
            end else if (out_ready) begin
               out_ctl.push       = 1'b1;
               out_ctl.res.done   = 1'b1;
               if (err_ff) begin
                  out_ctl.res.status = STAT_OVF;
               end else if (written_ff == exp_ff) begin
                  out_ctl.res.status = STAT_OK;
               end else begin
                  out_ctl.res.status = STAT_SHORT;
               end
               wpos_in    = FILL_POS;
               fill_in    = '0;
               tok_in     = '0;
               need_in    = NEED_W'(1);
               phase_in   = PH_FLAG;
               written_in = '0;
               err_in     = 1'b0;
               state_in   = S_LAST;
            end
         end
         S_LAST: begin
            out_ctl.flush = 1'b1;
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_put && out_ready) begin
         out_ctl.push = 1'b1;
         if (ovf) begin
            out_ctl.res.status = STAT_OVF;
            err_in             = 1'b1;
         end else begin
            out_ctl.res.data = put_data;
            out_ctl.res.has  = 1'b1;
            mem_wr_en        = 1'b1;
            mem_wr_data      = put_data;
            wpos_in          = wpos_ff + OFFSET_BITS'(1);
            written_in       = written_ff + SIZE_BITS'(1);
            if (fill_ff != FILL_FULL) begin
               fill_in = fill_ff + (OFFSET_BITS+1)'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_ff   <= PH_FLAG;
         need_ff    <= NEED_W'(1);
         tok_ff     <= '0;
         wpos_ff    <= FILL_POS;
         fill_ff    <= '0;
         written_ff <= '0;
         err_ff     <= 1'b0;
         exp_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         need_ff    <= need_in;
         tok_ff     <= tok_in;
         wpos_ff    <= wpos_in;
         fill_ff    <= fill_in;
         written_ff <= written_in;
         err_ff     <= err_in;
         exp_ff     <= exp_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      end_ff       <= end_in;
      bits_left_ff <= bits_left_in;
      src_ff       <= src_in;
      left_ff      <= left_in;
      hit_ff       <= hit_in;
      dflt_ff      <= dflt_in;
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("history fill count ran past the window size");

   a_copy_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COPY |-> $past(state_ff) == S_READ || $past(state_ff) == S_COPY)
      else $error("copy step without a preceding history read");

   a_bit_has_bits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_BIT && !err_ff |-> bits_left_ff != 4'd0)
      else $error("bit step with no bits left in the request");

   a_no_write_after_err: assert property (@(posedge clock) disable iff (reset)
      err_ff && state_ff != S_FIN && !(state_ff == S_IDLE && req_valid && req_stream_start)
      |=> written_ff == $past(written_ff))
      else $error("byte count moved after an overflow");
`endif

endmodule

`default_nettype wire

/* sv/lzd_top.sv */
`default_nettype none
// Reserved for top-level helpers of the LZSS decoder; it holds no logic at present.
// The decoder's top level is lzss_decoder_top, built on lzd_core, lzd_hist and lzd_out.

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for lzss_decoder_top: encodes LZSS streams, drives them as requests
// and checks every decoded byte and status item against a built-in decoder model.
// Depends on lzd_pkg and the decoder RTL; needs no files or arguments.

module testbench;
   import lzd_pkg::*;

   // Window geometry follows the package defaults the block is built with.
   localparam int OFF_W     = OFFSET_BITS_DEF;
   localparam int LEN_W     = LENGTH_BITS_DEF;
   localparam int TOK_W     = OFF_W + LEN_W;
   localparam int WIN_DEPTH = 1 << OFF_W;
   localparam int MAX_LEN   = (1 << LEN_W) - 1;
   // Start of the zero-filled tail of the window, also the first write position.
   localparam int FILL_END  = WIN_DEPTH - (1 << LEN_W) - 1;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int END_WAIT     = 20000;
   localparam int ITEMS_TOTAL  = 410;
   localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

   // One result as it should leave the block.
   typedef struct packed {
      logic [7:0] data;
      logic       has;
      logic       last;
      logic       done;
      status_type status;
   } decoded_type;

   // DUT ports; every input starts at a known value.
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_compressed_byte = '0;
   logic                 req_stream_start = 1'b0;
   logic                 req_stream_end = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_data_byte;
   logic                 rsp_has_byte;
   logic                 rsp_run_last;
   logic                 rsp_stream_done;
   logic [1:0]           rsp_status;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [SIZE_BITS-1:0] csr_expected_size = '0;

   // Decoder model state: history window, token assembly and stream counters.
   logic [7:0]           win_mem [WIN_DEPTH];
   logic [OFF_W-1:0]     win_pos;
   logic [TOK_W-1:0]     tok_bits;
   int                   bits_left;
   phase_type            tok_phase;
   logic [31:0]          out_count;
   bit                   ovf_seen;
   logic [SIZE_BITS-1:0] size_limit;

   // Results of the request being decoded, and all results still owed by the block.
   decoded_type          step_out[$];
   decoded_type          decoded_due[$];

   // Stream encoder: token bits waiting to be packed into bytes, and where the
   // decoder's write position should be so that copies can point at recent data.
   bit                   stream_bits[$];
   int                   gen_pos;
   int                   gen_total;

   // Run control and statistics.
   bit                   fast_mode = 1'b0;
   int                   hold_len = 0;
   int                   cycle_count = 0;
   int                   mismatch_count = 0;
   int                   req_count = 0;
   int                   rsp_count = 0;
   int                   cfg_writes = 0;
   int                   streams_sent = 0;
   int                   end_ok = 0;
   int                   end_short = 0;
   int                   end_ovf = 0;
   int                   ovf_reports = 0;

   lzss_decoder_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_compressed_byte (req_compressed_byte),
      .req_stream_start    (req_stream_start),
      .req_stream_end      (req_stream_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_has_byte        (rsp_has_byte),
      .rsp_run_last        (rsp_run_last),
      .rsp_stream_done     (rsp_stream_done),
      .rsp_status          (rsp_status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_expected_size   (csr_expected_size)
   );

   always #2 clock = ~clock;

   // Watchdog: a run that stops making progress ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: timeout after %0d cycles, %0d results still due",
                  cycle_count, decoded_due.size());
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("testbench: mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // ------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------

   // A new stream refills the window with spaces below the fill end and
   // zeros above, and clears the token and byte counters.
   function automatic void restart_stream();
      for (int a = 0; a < WIN_DEPTH; a++)
         win_mem[a] = (a < FILL_END) ? SPACE_CHAR : 8'h00;
      win_pos   = FILL_END[OFF_W-1:0];
      tok_bits  = '0;
      bits_left = 1;
      tok_phase = PH_FLAG;
      out_count = '0;
      ovf_seen  = 1'b0;
   endfunction

   function automatic void push_status(status_type st, logic is_final);
      step_out.push_back('{data: 8'h00, has: 1'b0, last: 1'b0, done: is_final, status: st});
   endfunction

   // Emits one decoded byte unless it would run past the declared size, in
   // which case an overflow status goes out instead and the stream is dead.
   function automatic bit store_byte(logic [7:0] c);
      if (out_count >= 32'(size_limit)) begin
         ovf_seen = 1'b1;
         push_status(STAT_OVF, 1'b0);
         return 1'b0;
      end
      step_out.push_back('{data: c, has: 1'b1, last: 1'b0, done: 1'b0, status: STAT_OK});
      out_count++;
      win_mem[win_pos] = c;
      win_pos++;
      return 1'b1;
   endfunction

   // Copies length+2 bytes one at a time, so a source that trails the write
   // position by less than the run length repeats the bytes just written.
   function automatic void copy_pair();
      logic [OFF_W-1:0] src;
      int               run;
      src = tok_bits[TOK_W-1:LEN_W];
      run = int'(tok_bits[LEN_W-1:0]) + 2;
      for (int k = 0; k < run; k++) begin
         if (!store_byte(win_mem[src]))
            return;
         src++;
      end
   endfunction

   function automatic void take_bit(bit b);
      if (tok_phase == PH_FLAG) begin
         tok_bits = '0;
         if (b) begin
            tok_phase = PH_LIT;
            bits_left = 8;
         end else begin
            tok_phase = PH_PAIR;
            bits_left = TOK_W;
         end
         return;
      end
      tok_bits = {tok_bits[TOK_W-2:0], b};
      bits_left--;
      if (bits_left != 0)
         return;
      if (tok_phase == PH_LIT)
         void'(store_byte(tok_bits[7:0]));
      else
         copy_pair();
      tok_phase = PH_FLAG;
      bits_left = 1;
      tok_bits  = '0;
   endfunction

   // Works out every result that one accepted request causes and queues them.
   function automatic void decode_request(logic [7:0] b, bit s, bit e);
      status_type st;
      step_out.delete();
      if (s)
         restart_stream();
      for (int i = 7; i >= 0 && !ovf_seen; i--)
         take_bit(b[i]);
      if (e) begin
         if (ovf_seen)
            st = STAT_OVF;
         else if (out_count == 32'(size_limit))
            st = STAT_OK;
         else
            st = STAT_SHORT;
         push_status(st, 1'b1);
         restart_stream();
      end
      if (step_out.size() > 0)
         step_out[step_out.size()-1].last = 1'b1;
      foreach (step_out[i])
         decoded_due.push_back(step_out[i]);
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Valid stays high after a request is taken; it only drops before an idle
   // gap, so back-to-back requests never lower and raise it in one step.
   task automatic send_request(logic [7:0] b, bit s, bit e);
      int gap;
      gap = fast_mode ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_compressed_byte <= b;
      req_stream_start    <= s;
      req_stream_end      <= e;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      req_count++;
      decode_request(b, s, e);
   endtask

   task automatic req_idle();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // The sender pauses until every owed result has arrived, then gives the
   // block time to finish a request that produced nothing.
   task automatic wait_drained();
      req_idle();
      while (decoded_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(logic [SIZE_BITS-1:0] value);
      wait_drained();
      csr_valid         <= 1'b1;
      csr_expected_size <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      size_limit = value;
      cfg_writes++;
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Stream encoder
   // ------------------------------------------------------------------

   function automatic void start_encoding();
      stream_bits.delete();
      gen_pos   = FILL_END;
      gen_total = 0;
   endfunction

   function automatic void add_literal(logic [7:0] c);
      stream_bits.push_back(1'b1);
      for (int i = 7; i >= 0; i--)
         stream_bits.push_back(c[i]);
      gen_total++;
      gen_pos = (gen_pos + 1) % WIN_DEPTH;
   endfunction

   function automatic void add_pair(int off, int len);
      logic [OFF_W-1:0] o;
      logic [LEN_W-1:0] l;
      o = off[OFF_W-1:0];
      l = len[LEN_W-1:0];
      stream_bits.push_back(1'b0);
      for (int i = OFF_W - 1; i >= 0; i--)
         stream_bits.push_back(o[i]);
      for (int i = LEN_W - 1; i >= 0; i--)
         stream_bits.push_back(l[i]);
      gen_total += int'(l) + 2;
      gen_pos = (gen_pos + int'(l) + 2) % WIN_DEPTH;
   endfunction

   // Offset that trails the write position by d bytes.
   function automatic int trailing(int d);
      return (gen_pos - d + WIN_DEPTH) % WIN_DEPTH;
   endfunction

   function automatic void add_random_token();
      int pick;
      int len;
      pick = $urandom_range(0, 9);
      len  = $urandom_range(0, MAX_LEN);
      if (pick < 4)
         add_literal(8'($urandom));
      else if (pick < 6)
         add_pair(trailing($urandom_range(1, len + 2)), len);   // overlapping copy
      else if (pick < 8)
         add_pair($urandom_range(0, WIN_DEPTH - 1), len);
      else if (pick == 8)
         add_pair(trailing($urandom_range(1, 40)), MAX_LEN);
      else
         add_pair(trailing($urandom_range(1, 2)), len);
   endfunction

   // Packs the queued bits into requests. A closing request is padded with
   // random bits, which form an incomplete token that the block must drop;
   // without a close, leftover bits wait for the next call.
   task automatic send_stream(bit with_start, bit with_end);
      logic [7:0] b;
      int         nbytes;
      if (with_end)
         while (stream_bits.size() % 8 != 0 || stream_bits.size() == 0)
            stream_bits.push_back(1'($urandom));
      nbytes = stream_bits.size() / 8;
      for (int i = 0; i < nbytes; i++) begin
         for (int j = 7; j >= 0; j--)
            b[j] = stream_bits.pop_front();
         send_request(b, with_start && i == 0, with_end && i == nbytes - 1);
      end
      streams_sent++;
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   // Unless fast mode is on, the receiver may lower ready before each result, and on
   // request holds ready low for a long counted stretch.
   initial begin : rsp_side
      int stall;
      wait (!reset);
      forever begin
         if (hold_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
         end
         stall = fast_mode ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready) && hold_len == 0)
            @(posedge clock);
      end
   end

   // Every accepted result is matched against the oldest owed one. The data
   // byte of a status item carries no meaning, so it is only checked when a
   // byte is expected.
   always @(posedge clock) begin : check_rsp
      decoded_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result data %02h has %0b done %0b status %0d",
                                      rsp_data_byte, rsp_has_byte, rsp_stream_done,
                                      rsp_status));
         end else begin
            want = decoded_due.pop_front();
            rsp_count++;
            if (rsp_has_byte !== want.has)
               report_mismatch($sformatf("result %0d: has_byte %0b, want %0b",
                                         rsp_count, rsp_has_byte, want.has));
            if (want.has && rsp_data_byte !== want.data)
               report_mismatch($sformatf("result %0d: data_byte %02h, want %02h",
                                         rsp_count, rsp_data_byte, want.data));
            if (rsp_run_last !== want.last)
               report_mismatch($sformatf("result %0d: run_last %0b, want %0b",
                                         rsp_count, rsp_run_last, want.last));
            if (rsp_stream_done !== want.done)
               report_mismatch($sformatf("result %0d: stream_done %0b, want %0b",
                                         rsp_count, rsp_stream_done, want.done));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("result %0d: status %0d, want %0d",
                                         rsp_count, rsp_status, want.status));
            if (want.done) begin
               case (want.status)
                  STAT_OK:    end_ok++;
                  STAT_SHORT: end_short++;
                  default:    end_ovf++;
               endcase
            end else if (!want.has) begin
               ovf_reports++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Literals at the byte extremes, copies from the zero tail and from the
   // space fill, the longest run, and a copy that overlaps its own output.
   // The size is set to its maximum, so the stream closes short.
   task automatic test_token_kinds();
      write_size(SIZE_MAX);
      start_encoding();
      add_pair(FILL_END, 0);
      add_literal(8'h00);
      add_literal(8'hFF);
      add_literal(8'h80);
      add_pair(0, MAX_LEN);
      add_pair(trailing(1), MAX_LEN);
      send_stream(1'b1, 1'b1);
   endtask

   // A stream that fills the declared size exactly closes ok; a single
   // request that both starts and ends a stream holds only a partial token.
   task automatic test_stream_status();
      start_encoding();
      add_literal(8'h41);
      add_literal(8'h42);
      add_pair(trailing(2), 3);
      write_size(SIZE_BITS'(gen_total));
      send_stream(1'b1, 1'b1);
      write_size('0);
      send_request(8'hFF, 1'b1, 1'b1);
   endtask

   // Overflow in the middle of a copy from the top of the window: the rest
   // of the stream is ignored. The request after the close opens a new
   // stream without a start flag.
   task automatic test_overflow();
      write_size(SIZE_BITS'(2));
      start_encoding();
      add_literal(8'($urandom));
      add_pair(WIN_DEPTH - 1, MAX_LEN);
      add_literal(8'h55);
      send_stream(1'b1, 1'b1);
      send_request(8'($urandom), 1'b0, 1'b1);
   endtask

   // The size changes between two halves of one stream and takes effect at
   // once, cutting the copy that follows short.
   task automatic test_mid_stream_config();
      write_size(SIZE_MAX);
      start_encoding();
      add_literal(8'h10);
      add_literal(8'h7F);
      add_literal(8'h01);
      send_stream(1'b1, 1'b0);
      write_size(SIZE_BITS'(4));
      add_pair(trailing(1), 3);
      send_stream(1'b0, 1'b1);
   endtask

   // Mostly well-formed streams with random tokens and a size that makes
   // them close ok, short or overflowed; the rest is random noise, streams
   // left open, and streams cut off mid-token.
   task automatic test_random_streams();
      int kind;
      int ntok;
      int sizing;
      bit with_start;
      bit with_end;
      while (req_count < ITEMS_TOTAL - 25) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            repeat ($urandom_range(1, 8))
               send_request(8'($urandom), $urandom_range(0, 3) == 0,
                            $urandom_range(0, 3) == 0);
         end else begin
            start_encoding();
            ntok = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
            repeat (ntok) add_random_token();
            if (kind == 1)
               repeat ($urandom_range(1, 10))
                  if (stream_bits.size() > 8)
                     void'(stream_bits.pop_back());
            sizing = $urandom_range(0, 9);
            if (sizing < 4)
               write_size(SIZE_BITS'(gen_total));
            else if (sizing == 4)
               write_size(SIZE_BITS'(gen_total + $urandom_range(1, 40)));
            else if (sizing == 5)
               write_size(SIZE_BITS'($urandom));
            else if (sizing < 8)
               write_size(SIZE_BITS'($urandom_range(0, gen_total - 1)));
            with_start = $urandom_range(0, 4) != 0;
            with_end   = $urandom_range(0, 7) != 0;
            if (stream_bits.size() < 8)
               with_end = 1'b1;
            fast_mode = $urandom_range(0, 5) == 0;
            send_stream(with_start, with_end);
            fast_mode = 1'b0;
         end
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering a stream of maximum-length copies, so the block backs up and
   // stops taking requests; afterwards everything must drain in order.
   task automatic test_backpressure();
      write_size(SIZE_MAX);
      hold_len = HOLD_CYCLES;
      start_encoding();
      add_literal(8'h2A);
      repeat (10) add_pair(trailing($urandom_range(1, 20)), MAX_LEN);
      send_stream(1'b1, 1'b1);
      wait_drained();
   endtask

   initial begin : run_tests
      size_limit = '0;
      restart_stream();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_token_kinds();
      test_stream_status();
      test_overflow();
      test_mid_stream_config();
      test_random_streams();
      test_backpressure();

      // Final drain with its own bound; leftovers and late extra results fail.
      for (int n = 0; n < END_WAIT && decoded_due.size() != 0; n++)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (decoded_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", decoded_due.size()));

      $display("testbench: %0d requests in %0d streams, %0d results checked, %0d size writes",
               req_count, streams_sent, rsp_count, cfg_writes);
      $display("testbench: stream ends ok %0d, short %0d, overflow %0d; %0d overflow reports",
               end_ok, end_short, end_ovf, ovf_reports);
      if (mismatch_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

/* files.f */
sv/lzd_pkg.sv
sv/lzd_hist.sv
sv/lzd_out.sv
sv/lzd_core.sv
sv/lzd_top.sv
sv/lzss_decoder_top.sv
tb/sv/testbench.sv
